### design/fkd_pkg.sv
// ----------------------------------------------------------------------------
// fkd_pkg
// Shared types and constants of the four-key debouncer with long-press events.
// ----------------------------------------------------------------------------
package fkd_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NUM_KEYS      = 4;
  localparam int NOW_W         = 32;
  localparam int MS_W          = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int EV_W          = 3;

  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [MS_W-1:0] LONG_RST     = 16'd1200;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [EV_W-1:0] {
    EV_NONE       = 3'd0,
    EV_FUNC_SHORT = 3'd1,
    EV_FUNC_LONG  = 3'd2,
    EV_PLUS       = 3'd3,
    EV_MINUS      = 3'd4,
    EV_OK         = 3'd5
  } ev_t;

  // what one lane reports to the merge stage for the current tick
  typedef struct packed {
    logic stable_nxt;
    logic rise;
    logic fall;
  } lane_st_t;

  typedef struct packed {
    logic [EV_W-1:0]     event_code;
    logic [NUM_KEYS-1:0] stable_keys;
  } res_t;

endpackage

### design/fkd_if.sv
// ----------------------------------------------------------------------------
// fkd_if
// Valid/ready channels of the debouncer: input items, results, configuration.
// ----------------------------------------------------------------------------
interface fkd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [fkd_pkg::NOW_W-1:0]    now_time;
  logic [fkd_pkg::NUM_KEYS-1:0] raw_pressed;
  modport source (output valid, operation, now_time, raw_pressed, input ready);
  modport sink   (input valid, operation, now_time, raw_pressed, output ready);
endinterface

interface fkd_out_if;
  logic                        valid;
  logic                        ready;
  logic [fkd_pkg::EV_W-1:0]     event_code;
  logic [fkd_pkg::NUM_KEYS-1:0] stable_keys;
  modport source (output valid, event_code, stable_keys, input ready);
  modport sink   (input valid, event_code, stable_keys, output ready);
endinterface

interface fkd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fkd_pkg::CFG_IDX_W-1:0] index;
  logic [fkd_pkg::MS_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/four_key_debounce_long_press_events.sv
// Each accepted item's result is registered into the output register, or into the skid entry while it is stalled.
// Throughput: one item per cycle while the skid entry is free; every lane and the slot merge are combinational.
// A two-entry output buffer lets input items keep flowing for one stalled result.
// Reset (synchronous, rst_n low) clears levels, timers, slot and buffer, and
// loads debounce_ms = 30 and long_press_ms = 1200. No clearing pass is needed.
// ----------------------------------------------------------------------------
// four_key_debounce_long_press_events
// Four debounce lanes feed a merge stage that posts key events into one slot.
// ----------------------------------------------------------------------------
module four_key_debounce_long_press_events #(
  parameter int TIME_BITS = fkd_pkg::TIME_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  fkd_in_if.sink         in_ch,
  fkd_out_if.source      out_ch,
  fkd_cfg_if.sink        cfg_ch
);
  import fkd_pkg::*;

  logic [MS_W-1:0]      debounce_r, long_r;
  logic                 accept, tick, fetch;
  logic [TIME_BITS-1:0] now;
  lane_st_t [NUM_KEYS-1:0] st;
  logic [NUM_KEYS-1:0]  stable_all;
  logic [EV_W-1:0]      code;
  res_t                 res;
  res_t                 main_r, skid_r;
  logic                 main_v_r, skid_v_r;
  logic                 pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_DEBOUNCE) debounce_r <= cfg_ch.data;
      if (cfg_ch.index == CFG_LONG)     long_r     <= cfg_ch.data;
    end
  end

  assign in_ch.ready = !skid_v_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick        = accept && (in_ch.operation == OP_TICK);
  assign fetch       = accept && (in_ch.operation == OP_FETCH);
  assign now         = TIME_BITS'(in_ch.now_time);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    fkd_lane #(.TIME_BITS(TIME_BITS)) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .tick        (tick),
      .now         (now),
      .lvl         (in_ch.raw_pressed[k]),
      .debounce_ms (debounce_r),
      .st          (st[k])
    );
    assign stable_all[k] = st[k].stable_nxt;
  end

  fkd_merge #(.TIME_BITS(TIME_BITS)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .fetch      (fetch),
    .now        (now),
    .long_ms    (long_r),
    .st         (st),
    .event_code (code)
  );

  assign res.event_code  = code;
  assign res.stable_keys = stable_all;

  // output register plus skid entry
  assign pop = main_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r) begin
        main_v_r <= accept;
      end else if (pop) begin
        main_v_r <= skid_v_r || accept;
        skid_v_r <= 1'b0;
      end else if (accept) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || (pop && !skid_v_r)) begin
      main_r <= res;
    end else if (pop) begin
      main_r <= skid_r;
    end
    if (main_v_r && !pop && accept) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid       = main_v_r;
  assign out_ch.event_code  = main_r.event_code;
  assign out_ch.stable_keys = main_r.stable_keys;

endmodule

### design/fkd_lane.sv
// ----------------------------------------------------------------------------
// fkd_lane
// Debounce lane for one key: raw level tracking, change time and stable level.
// ----------------------------------------------------------------------------
module fkd_lane #(
  parameter int TIME_BITS = fkd_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tick,
  input  logic [TIME_BITS-1:0]      now,
  input  logic                      lvl,
  input  logic [fkd_pkg::MS_W-1:0]  debounce_ms,
  output fkd_pkg::lane_st_t         st
);
  import fkd_pkg::*;

  logic                 last_r, last_nxt;
  logic                 stable_r, stable_nxt;
  logic [TIME_BITS-1:0] change_r, change_nxt;
  logic [TIME_BITS-1:0] held;
  logic                 accept;

  always_comb begin
    last_nxt   = last_r;
    change_nxt = change_r;
    if (tick && (lvl != last_r)) begin
      last_nxt   = lvl;
      change_nxt = now;
    end
    held       = now - change_nxt;
    accept     = tick && (lvl != stable_r) && (held >= TIME_BITS'(debounce_ms));
    stable_nxt = accept ? lvl : stable_r;
  end

  assign st.stable_nxt = stable_nxt;
  assign st.rise       = accept && lvl;
  assign st.fall       = accept && !lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b0;
      stable_r <= 1'b0;
      change_r <= '0;
    end else begin
      last_r   <= last_nxt;
      stable_r <= stable_nxt;
      change_r <= change_nxt;
    end
  end

endmodule

### design/fkd_merge.sv
// ----------------------------------------------------------------------------
// fkd_merge
// Combines lane findings in key order into the event slot; long-press timing.
// ----------------------------------------------------------------------------
module fkd_merge #(
  parameter int TIME_BITS = fkd_pkg::TIME_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      tick,
  input  logic                                      fetch,
  input  logic [TIME_BITS-1:0]                      now,
  input  logic [fkd_pkg::MS_W-1:0]                  long_ms,
  input  fkd_pkg::lane_st_t [fkd_pkg::NUM_KEYS-1:0] st,
  output logic [fkd_pkg::EV_W-1:0]                  event_code
);
  import fkd_pkg::*;

  ev_t                  slot_r, slot_nxt;
  logic [TIME_BITS-1:0] press_r, press_nxt;
  logic                 sent_r, sent_nxt;
  logic                 sent_mid;
  logic                 long_hit;

  always_comb begin
    slot_nxt  = slot_r;
    press_nxt = press_r;
    sent_nxt  = sent_r;
    sent_mid  = st[0].rise ? 1'b0 : sent_r;
    press_nxt = (tick && st[0].rise) ? now : press_r;
    long_hit  = st[0].stable_nxt && !sent_mid &&
                ((now - press_nxt) >= TIME_BITS'(long_ms));
    event_code = EV_NONE;
    if (fetch) begin
      event_code = slot_r;
      slot_nxt   = EV_NONE;
    end else if (tick) begin
      sent_nxt = sent_mid;
      if (slot_r == EV_NONE) begin
        // function key first, then plus, minus, ok; slot takes the first one
        priority if (st[0].fall && !sent_r) begin
          slot_nxt = EV_FUNC_SHORT;
        end else if (long_hit) begin
          slot_nxt = EV_FUNC_LONG;
          sent_nxt = 1'b1;
        end else if (st[1].fall) begin
          slot_nxt = EV_PLUS;
        end else if (st[2].fall) begin
          slot_nxt = EV_MINUS;
        end else if (st[3].fall) begin
          slot_nxt = EV_OK;
        end else begin
          slot_nxt = EV_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= EV_NONE;
      press_r <= '0;
      sent_r  <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      press_r <= press_nxt;
      sent_r  <= sent_nxt;
    end
  end

endmodule

### design/fkd_chk.sv
// ----------------------------------------------------------------------------
// fkd_chk
// Port-level checks of the debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module fkd_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fkd_pkg::EV_W-1:0]     event_code,
  input logic [fkd_pkg::NUM_KEYS-1:0] stable_keys,
  input logic                        cfg_ready
);
  import fkd_pkg::*;

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // an item taken while the buffer is empty shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("accepted item did not produce a result");

  // only defined event codes leave the block
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (event_code == EV_NONE || event_code == EV_FUNC_SHORT ||
                   event_code == EV_FUNC_LONG || event_code == EV_PLUS ||
                   event_code == EV_MINUS || event_code == EV_OK))
    else $error("undefined event code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_code) &&
                                $stable(stable_keys))
    else $error("stalled result changed");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind four_key_debounce_long_press_events fkd_chk u_fkd_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_code  (out_ch.event_code),
  .stable_keys (out_ch.stable_keys),
  .cfg_ready   (cfg_ch.ready)
);

### bench/four_key_debounce_long_press_events_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_key_debounce_long_press_events_test
// Drives tick and fetch items with bouncing key levels against a running
// millisecond clock, under several debounce and long-press settings, and
// checks every result against a cycle-free model of the event logic.
// ----------------------------------------------------------------------------
module four_key_debounce_long_press_events_test;
  import fkd_pkg::*;

  typedef struct packed {
    logic                op;
    logic [NOW_W-1:0]    now;
    logic [NUM_KEYS-1:0] raw;
  } key_item_t;

  logic clk;
  logic rst_n;

  fkd_in_if  in_bus ();
  fkd_out_if out_bus ();
  fkd_cfg_if cfg_bus ();

  four_key_debounce_long_press_events i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // model state
  logic [MS_W-1:0]     deb_ms;
  logic [MS_W-1:0]     hold_ms;
  logic [NUM_KEYS-1:0] lvl_last;
  logic [NUM_KEYS-1:0] lvl_stable;
  logic [NOW_W-1:0]    chg_time [NUM_KEYS];
  logic [NOW_W-1:0]    press_t;
  logic                fkey_long_done;
  ev_t                 slot;

  key_item_t pending_q[$];
  res_t      event_q[$];
  int        err_cnt;
  bit        in_taken;
  bit        calm_run;
  int        in_gap;
  int        out_gap;
  res_t      want;

  // stimulus state: running clock and the levels the "user" holds
  logic [NOW_W-1:0]    ms_now;
  logic [NUM_KEYS-1:0] intent;

  function automatic res_t key_event_step(key_item_t it);
    res_t             r;
    logic [NOW_W-1:0] dt;
    logic             lvl;
    r.event_code = EV_NONE;
    if (it.op == OP_FETCH) begin
      r.event_code = slot;
      slot = EV_NONE;
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        lvl = it.raw[k];
        if (lvl != lvl_last[k]) begin
          lvl_last[k] = lvl;
          chg_time[k] = it.now;
        end
        dt = it.now - chg_time[k];
        if (lvl != lvl_stable[k] && dt >= {16'd0, deb_ms}) begin
          lvl_stable[k] = lvl;
          if (lvl) begin
            if (k == 0) begin
              press_t        = it.now;
              fkey_long_done = 1'b0;
            end
          end else if (slot == EV_NONE) begin
            if (k == 0) begin
              if (!fkey_long_done) slot = EV_FUNC_SHORT;
            end else begin
              slot = (k == 1) ? EV_PLUS : (k == 2) ? EV_MINUS : EV_OK;
            end
          end
        end
        dt = it.now - press_t;
        // a long event blocked by a full slot is retried on later ticks
        if (k == 0 && lvl_stable[0] && !fkey_long_done && dt >= {16'd0, hold_ms} &&
            slot == EV_NONE) begin
          fkey_long_done = 1'b1;
          slot           = EV_FUNC_LONG;
        end
      end
    end
    r.stable_keys = lvl_stable;
    return r;
  endfunction

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (event_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: event %0d keys %b",
                     out_bus.event_code, out_bus.stable_keys);
        end else begin
          want = event_q.pop_front();
          if (out_bus.event_code !== want.event_code ||
              out_bus.stable_keys !== want.stable_keys) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected event %0d keys %b, got event %0d keys %b",
                       want.event_code, want.stable_keys,
                       out_bus.event_code, out_bus.stable_keys);
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == CFG_DEBOUNCE) deb_ms = cfg_bus.data;
        else if (cfg_bus.index == CFG_LONG) hold_ms = cfg_bus.data;
      end
      in_taken = in_bus.valid && in_bus.ready;
      if (in_taken)
        event_q.push_back(key_event_step('{in_bus.operation, in_bus.now_time,
                                           in_bus.raw_pressed}));
    end
  end

  // input driver
  always @(negedge clk) begin
    key_item_t it;
    logic      v;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!(in_bus.valid && !in_taken)) begin
      v = 1'b0;
      it = '0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (!calm_run && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 13) - 1;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        v = 1'b1;
      end
      in_bus.valid <= v;
      if (v) begin
        in_bus.operation   <= it.op;
        in_bus.now_time    <= it.now;
        in_bus.raw_pressed <= it.raw;
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    logic r;
    r = 1'b1;
    if (out_gap > 0) begin
      out_gap--;
      r = 1'b0;
    end else if (!calm_run && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 13) - 1;
      r = 1'b0;
    end
    out_bus.ready <= r;
  end

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic push_tick(logic [NOW_W-1:0] now, logic [NUM_KEYS-1:0] raw);
    pending_q.push_back('{OP_TICK, now, raw});
  endtask

  task automatic push_fetch();
    pending_q.push_back('{OP_FETCH, NOW_W'($urandom), NUM_KEYS'($urandom)});
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_bus.valid || event_q.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // key presses with random hold times, bounce and fetches in between
  task automatic gen_phase(int n, int unsigned step_max, int unsigned toggle_den);
    logic [NUM_KEYS-1:0] bounce;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_fetch();
      end else begin
        if ($urandom_range(0, 24) == 0) ms_now += $urandom;
        else ms_now += $urandom_range(0, step_max);
        for (int k = 0; k < NUM_KEYS; k++) begin
          if ($urandom_range(0, toggle_den - 1) == 0) intent[k] = ~intent[k];
          bounce[k] = ($urandom_range(0, 9) == 0);
        end
        push_tick(ms_now, intent ^ bounce);
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.operation      = OP_TICK;
    in_bus.now_time       = '0;
    in_bus.raw_pressed    = '0;
    out_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_DEBOUNCE;
    cfg_bus.data          = '0;
    deb_ms                = DEBOUNCE_RST;
    hold_ms               = LONG_RST;
    lvl_last              = '0;
    lvl_stable            = '0;
    fkey_long_done        = 1'b0;
    press_t               = '0;
    slot                  = EV_NONE;
    for (int k = 0; k < NUM_KEYS; k++) chg_time[k] = '0;
    err_cnt               = 0;
    in_gap                = 0;
    out_gap               = 0;
    calm_run              = 1'b0;
    intent                = '0;
    ms_now                = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings
    push_tick(32'd0, 4'b0000);
    push_fetch();
    push_tick(32'd100, 4'b0001);
    push_tick(32'd130, 4'b0001);
    push_tick(32'd1330, 4'b0001);    // long press reached
    push_fetch();
    push_tick(32'd1400, 4'b0000);
    push_tick(32'd1430, 4'b0000);    // release after long: no short event
    push_tick(32'd2000, 4'b0001);
    push_tick(32'd2030, 4'b0001);
    push_tick(32'd2100, 4'b0000);
    push_tick(32'd2130, 4'b0000);    // short press
    push_fetch();
    push_tick(32'd3000, 4'b1110);
    push_tick(32'd3030, 4'b1110);
    push_tick(32'd3100, 4'b0000);
    push_tick(32'd3130, 4'b0000);    // three releases, slot takes only the first
    push_fetch();
    push_tick(32'hFFFF_FFF0, 4'b1000);
    push_tick(32'h0000_0010, 4'b1000);  // debounce across the timestamp wrap
    push_tick(32'h0000_0020, 4'b0000);
    push_tick(32'h0000_0040, 4'b0000);
    push_fetch();
    push_tick(32'hFFFF_FFFF, 4'b1111);
    push_fetch();
    wait_drained();

    // zero hold times
    put_reg(CFG_DEBOUNCE, 16'd0);
    put_reg(CFG_LONG, 16'd0);
    ms_now = $urandom;
    gen_phase(100, 3, 4);
    wait_drained();

    // largest hold times, large time steps
    put_reg(CFG_DEBOUNCE, 16'hFFFF);
    put_reg(CFG_LONG, 16'hFFFF);
    ms_now = $urandom;
    gen_phase(100, 30000, 3);
    wait_drained();

    // short hold times, running through the wrap
    put_reg(CFG_DEBOUNCE, 16'd2);
    put_reg(CFG_LONG, 16'd12);
    ms_now = 32'hFFFF_FF80;
    gen_phase(120, 3, 6);
    wait_drained();

    // longer holds; sender pauses halfway until all results are in
    put_reg(CFG_DEBOUNCE, 16'd5);
    put_reg(CFG_LONG, 16'd40);
    ms_now = $urandom;
    gen_phase(60, 4, 10);
    wait_drained();
    gen_phase(60, 4, 10);
    wait_drained();

    put_reg(CFG_DEBOUNCE, 16'hFFFF);
    put_reg(CFG_LONG, 16'd0);
    ms_now = $urandom;
    gen_phase(60, 25000, 4);
    wait_drained();

    // random settings, no stalls on either side
    put_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 8)));
    put_reg(CFG_LONG, 16'($urandom_range(0, 60)));
    calm_run = 1'b1;
    ms_now = $urandom;
    gen_phase(200, 4, 7);
    wait_drained();
    repeat (5) @(posedge clk);

    if (err_cnt == 0 && event_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
